/* hw/rtl/isch_pkg.sv */
// shared constants and helpers for the inline span context hasher
package isch_pkg;

  // span kind codes as they appear on the result word
  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_BACKTICK = 2'd1;
  localparam logic [1:0] KIND_DOLLAR   = 2'd2;

  // delimiter characters
  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [7:0] CHAR_BACKTICK = 8'h60;
  localparam logic [7:0] CHAR_DOLLAR   = 8'h24;

  // hash constants
  localparam logic [63:0] MIX_MULT      = 64'd6364136223846793005;
  localparam logic [63:0] SEED_BACKTICK = 64'hD1E2_F3A4_B5C6_0718;
  localparam logic [63:0] SEED_DOLLAR   = 64'h3C4D_5E6F_7A8B_9CA0;

  // interior count saturation and bucket placement
  localparam logic [3:0] COUNT_MAX    = 4'd12;
  localparam int unsigned BUCKET_SHIFT = 60;

  // seed for a span kind, an unused code gets seed zero
  function automatic logic [63:0] kind_seed(input logic [1:0] kind);
    logic [63:0] seed;
    case (kind)
      KIND_BACKTICK: seed = SEED_BACKTICK;
      KIND_DOLLAR:   seed = SEED_DOLLAR;
      default:       seed = 64'd0;
    endcase
    return seed;
  endfunction

  // position bucket of the interior count
  function automatic logic [2:0] count_bucket(input logic [3:0] n);
    logic [2:0] b;
    if (n == 4'd0) begin
      b = 3'd0;
    end else if (n <= 4'd2) begin
      b = 3'd1;
    end else if (n <= 4'd5) begin
      b = 3'd2;
    end else if (n <= 4'd11) begin
      b = 3'd3;
    end else begin
      b = 3'd4;
    end
    return b;
  endfunction

endpackage

/* hw/rtl/isch_byte_if.sv */
// input channel carrying one text byte per word
interface isch_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

/* hw/rtl/isch_res_if.sv */
// result channel carrying span kind, eligibility and context key
interface isch_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  span_kind;
  logic        in_span;
  logic [63:0] context_key;

  modport source (output valid, output span_kind, output in_span, output context_key,
                  input ready);
  modport sink   (input valid, input span_kind, input in_span, input context_key,
                  output ready);
endinterface

/* hw/rtl/inline_span_context_hasher_core.sv */
// Inline span tracker with a 64-bit prefix hash and context key per byte.
// Each accepted byte passes through the input register, then the span update and the
// result register, which holds its result word.
// Throughput: one byte per cycle while the result channel is not stalled; the hash
// multiply (three 32x32 partial products) sits in the span state feedback loop.
// Reset: asynchronous active low; no span open, digest and count zero, both stages empty.
module inline_span_context_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  isch_byte_if.sink   byte_i,
  isch_res_if.source  res_o
);

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // span state
  logic [1:0]  kind_q, kind_d;
  logic [63:0] digest_q, digest_d;
  logic [3:0]  count_q, count_d;

  // result register
  logic        out_vld_q;
  logic [1:0]  out_kind_q;
  logic        out_span_q;
  logic [63:0] out_key_q;

  logic advance;
  logic in_ready;

  // pipeline handshake
  assign advance  = in_vld_q && (!out_vld_q || res_o.ready);
  assign in_ready = !in_vld_q || advance;
  assign byte_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && byte_i.valid) begin
      in_byte_q <= byte_i.text_byte;
    end
  end

  // digest times multiplier, low 64 bits from three 32x32 partial products
  logic [63:0] pp_lo;
  logic [31:0] pp_mid_a;
  logic [31:0] pp_mid_b;
  logic [31:0] mid_sum;
  logic [63:0] mixed;

  always_comb begin
    pp_lo    = digest_q[31:0] * isch_pkg::MIX_MULT[31:0];
    pp_mid_a = digest_q[31:0] * isch_pkg::MIX_MULT[63:32];
    pp_mid_b = digest_q[63:32] * isch_pkg::MIX_MULT[31:0];
    mid_sum  = pp_mid_a + pp_mid_b;
    mixed    = pp_lo + {mid_sum, 32'd0};
  end

  // span update for the byte in the input register
  always_comb begin
    kind_d   = kind_q;
    digest_d = digest_q;
    count_d  = count_q;
    if (in_byte_q == isch_pkg::CHAR_NEWLINE) begin
      kind_d   = isch_pkg::KIND_NONE;
      digest_d = 64'd0;
      count_d  = 4'd0;
    end else if (kind_q == isch_pkg::KIND_NONE) begin
      if (in_byte_q == isch_pkg::CHAR_BACKTICK) begin
        kind_d   = isch_pkg::KIND_BACKTICK;
        digest_d = 64'd0;
        count_d  = 4'd0;
      end else if (in_byte_q == isch_pkg::CHAR_DOLLAR) begin
        kind_d   = isch_pkg::KIND_DOLLAR;
        digest_d = 64'd0;
        count_d  = 4'd0;
      end
    end else if ((kind_q == isch_pkg::KIND_BACKTICK && in_byte_q == isch_pkg::CHAR_BACKTICK) ||
                 (kind_q == isch_pkg::KIND_DOLLAR && in_byte_q == isch_pkg::CHAR_DOLLAR)) begin
      kind_d   = isch_pkg::KIND_NONE;
      digest_d = 64'd0;
      count_d  = 4'd0;
    end else begin
      digest_d = mixed ^ {56'd0, in_byte_q};
      if (count_q < isch_pkg::COUNT_MAX) begin
        count_d = count_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= isch_pkg::KIND_NONE;
      digest_q <= 64'd0;
      count_q  <= 4'd0;
    end else if (advance) begin
      kind_q   <= kind_d;
      digest_q <= digest_d;
      count_q  <= count_d;
    end
  end

  // context key from the updated state
  logic [63:0] bucket_word;
  logic [63:0] key_d;

  always_comb begin
    bucket_word = {61'd0, isch_pkg::count_bucket(count_d)} << isch_pkg::BUCKET_SHIFT;
    key_d       = isch_pkg::kind_seed(kind_d) ^ digest_d ^ bucket_word;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_kind_q <= kind_d;
      out_span_q <= (kind_d != isch_pkg::KIND_NONE);
      out_key_q  <= key_d;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.span_kind   = out_kind_q;
  assign res_o.in_span     = out_span_q;
  assign res_o.context_key = out_key_q;

endmodule
